// ===== rtl/pbd_pkg.sv =====
package pbd_pkg;

  localparam int PbdFrames  = 16;
  localparam int FileW      = 8;
  localparam int PageW      = 24;
  localparam int PinW       = 8;
  localparam int FrameOutW  = 4;
  localparam int MaxResults = 16;

  typedef enum logic [2:0] {
    OP_FETCH  = 3'd0,
    OP_UNPIN  = 3'd1,
    OP_FLUSH  = 3'd2,
    OP_NEW    = 3'd3,
    OP_DELETE = 3'd4,
    OP_FLUSH_ALL = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_RES    = 3'd1,
    ST_NO_FRAME   = 3'd2,
    ST_NOT_PINNED = 3'd3,
    ST_PINNED     = 3'd4,
    ST_INVALID    = 3'd5
  } status_e;

  // Per-frame update command.
  typedef struct packed {
    logic load;
    logic kill;
    logic pin_inc;
    logic pin_dec;
    logic dirty_we;
    logic dirty_val;
  } frame_cmd_t;

  // Per-slot chain command.
  typedef struct packed {
    logic take_next;
    logic take_prev;
    logic load;
  } slot_cmd_t;

endpackage

// ===== rtl/pbd_frame_cell.sv =====
module pbd_frame_cell
  import pbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  frame_cmd_t       cmd_i,
  input  logic [FileW-1:0] file_i,
  input  logic [PageW-1:0] page_i,
  output logic             valid_o,
  output logic [FileW-1:0] file_o,
  output logic [PageW-1:0] page_o,
  output logic [PinW-1:0]  pin_o,
  output logic             dirty_o
);

  logic             valid_q, valid_d, dirty_q, dirty_d;
  logic [PinW-1:0]  pin_q, pin_d;
  logic [FileW-1:0] file_q;
  logic [PageW-1:0] page_q;

  // Control state of one frame.
  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    pin_d   = pin_q;
    if (cmd_i.load) begin
      valid_d = 1'b1;
      dirty_d = 1'b0;
      pin_d   = PinW'(1);
    end else begin
      if (cmd_i.kill) begin
        valid_d = 1'b0;
        dirty_d = 1'b0;
      end
      if (cmd_i.pin_inc && pin_q != {PinW{1'b1}}) pin_d = pin_q + PinW'(1);
      if (cmd_i.pin_dec && pin_q != '0) pin_d = pin_q - PinW'(1);
      if (cmd_i.dirty_we) dirty_d = cmd_i.dirty_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      pin_q   <= '0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      pin_q   <= pin_d;
    end
  end

  // Tags are written only when a page is loaded.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      file_q <= file_i;
      page_q <= page_i;
    end
  end

  assign valid_o = valid_q;
  assign file_o  = file_q;
  assign page_o  = page_q;
  assign pin_o   = pin_q;
  assign dirty_o = dirty_q;

endmodule

// ===== rtl/pbd_slot_cell.sv =====
module pbd_slot_cell
  import pbd_pkg::*;
#(
  parameter int IdxW   = 4,
  parameter int RstVal = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  slot_cmd_t       cmd_i,
  input  logic [IdxW-1:0] next_i,
  input  logic [IdxW-1:0] prev_i,
  input  logic [IdxW-1:0] load_i,
  output logic [IdxW-1:0] val_o
);

  logic [IdxW-1:0] val_q, val_d;

  // One position of a frame-index chain; it shifts toward either neighbor.
  always_comb begin
    val_d = val_q;
    if (cmd_i.load) val_d = load_i;
    else if (cmd_i.take_next) val_d = next_i;
    else if (cmd_i.take_prev) val_d = prev_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) val_q <= IdxW'(RstVal);
    else val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== rtl/page_buffer_directory_lru.sv =====
// Buffer pool frame directory with LRU replacement. One request word is taken
// at a time: it is accepted in S_IDLE, executed in S_EXEC and its result word
// is handed over from S_SEND, which waits while the output is held off. A
// flush-all walks the frames one per cycle while the output is free and emits
// one result word per matching frame, at most MaxResults of them. Frames, the
// free stack and the LRU list are rows of small cells; the stack and list shift
// one position per update.
module page_buffer_directory_lru
  import pbd_pkg::*;
#(
  parameter int POOL_FRAMES = PbdFrames
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[2:0], file_id[10:3], page_no[34:11], negative[35], mark_dirty[36],
  // allocated_page_no[60:37]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], frame_index[6:3], write_back[7], wb_file_id[15:8],
  // wb_page_no[39:16], read_in[40]
  output logic [47:0] m_tdata,
  output logic        m_tlast
);

  localparam int FW = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int CW = $clog2(POOL_FRAMES + 1);
  localparam int RW = $clog2(MaxResults + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SEND = 4'b0100,
    S_SCAN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Request registers.
  logic [2:0]       op_q;
  logic [FileW-1:0] fid_q;
  logic [PageW-1:0] pno_q, alloc_q;
  logic             neg_q, md_q;

  // Output register.
  logic             ov_q, ov_d, ol_q, ol_d;
  logic [40:0]      od_q, od_d;

  logic [FW-1:0]    k_q, k_d;
  logic [RW-1:0]    n_q, n_d;
  logic [CW-1:0]    free_cnt_q, free_cnt_d, lru_cnt_q, lru_cnt_d;

  // Cell arrays.
  frame_cmd_t       fcmd [POOL_FRAMES];
  logic             fv   [POOL_FRAMES];
  logic [FileW-1:0] ff   [POOL_FRAMES];
  logic [PageW-1:0] fp   [POOL_FRAMES];
  logic [PinW-1:0]  fpin [POOL_FRAMES];
  logic             fd   [POOL_FRAMES];
  logic [PageW-1:0] load_page;

  slot_cmd_t        fs_cmd [POOL_FRAMES];
  slot_cmd_t        lr_cmd [POOL_FRAMES];
  logic [FW-1:0]    fs_val [POOL_FRAMES];
  logic [FW-1:0]    lr_val [POOL_FRAMES];
  logic [FW-1:0]    fs_load, lr_load;

  logic [POOL_FRAMES-1:0] hit_vec, fa_vec, lr_seen;
  logic             hit_any;
  logic [FW-1:0]    hit_idx;
  logic [PageW-1:0] key_page;

  logic             out_free;
  assign out_free = !ov_q || m_tready;
  assign s_tready = (state_q == S_IDLE);

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      op_q    <= s_tdata[2:0];
      fid_q   <= s_tdata[10:3];
      pno_q   <= s_tdata[34:11];
      neg_q   <= s_tdata[35];
      md_q    <= s_tdata[36];
      alloc_q <= s_tdata[60:37];
    end
  end

  // Frame cells and their match lines.
  for (genvar g = 0; g < POOL_FRAMES; g++) begin : g_frame
    pbd_frame_cell u_frame (
      .clk_i, .rst_ni, .cmd_i(fcmd[g]), .file_i(fid_q), .page_i(load_page),
      .valid_o(fv[g]), .file_o(ff[g]), .page_o(fp[g]), .pin_o(fpin[g]), .dirty_o(fd[g])
    );
    assign hit_vec[g] = fv[g] && ff[g] == fid_q && fp[g] == key_page;
    assign fa_vec[g]  = fv[g] && ff[g] == fid_q;
  end

  assign key_page = (op_q == OP_NEW) ? alloc_q : pno_q;

  // Page tags are unique, so the hit index is an OR of the matching indexes.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < POOL_FRAMES; i++)
      if (hit_vec[i]) hit_idx = hit_idx | FW'(i);
  end
  assign hit_any = |hit_vec;

  // Free stack and LRU list chains.
  for (genvar g = 0; g < POOL_FRAMES; g++) begin : g_slot
    logic [FW-1:0] fs_next, fs_prev, lr_next, lr_prev;
    if (g == POOL_FRAMES - 1) begin : g_end
      assign fs_next = fs_val[g];
      assign lr_next = lr_val[g];
    end else begin : g_mid
      assign fs_next = fs_val[g+1];
      assign lr_next = lr_val[g+1];
    end
    if (g == 0) begin : g_top
      assign fs_prev = fs_val[g];
      assign lr_prev = lr_val[g];
    end else begin : g_low
      assign fs_prev = fs_val[g-1];
      assign lr_prev = lr_val[g-1];
    end
    pbd_slot_cell #(.IdxW(FW), .RstVal(g)) u_free (
      .clk_i, .rst_ni, .cmd_i(fs_cmd[g]), .next_i(fs_next), .prev_i(fs_prev),
      .load_i(fs_load), .val_o(fs_val[g])
    );
    pbd_slot_cell #(.IdxW(FW), .RstVal(0)) u_lru (
      .clk_i, .rst_ni, .cmd_i(lr_cmd[g]), .next_i(lr_next), .prev_i(lr_prev),
      .load_i(lr_load), .val_o(lr_val[g])
    );
  end

  // Request execution and flush-all scan.
  always_comb begin
    logic          do_load, do_rm, do_push, do_app, pop, victim;
    logic [FW-1:0] tgt, rm_f;
    logic [2:0]    st;
    logic          wb, rd;
    logic [FileW-1:0] wf;
    logic [PageW-1:0] wp;
    logic          lst;
    logic [POOL_FRAMES-1:0] higher;

    state_d    = state_q;
    ov_d       = ov_q && !m_tready;
    ol_d       = ol_q;
    od_d       = od_q;
    k_d        = k_q;
    n_d        = n_q;
    free_cnt_d = free_cnt_q;
    lru_cnt_d  = lru_cnt_q;
    load_page  = key_page;
    do_load = 1'b0; do_rm = 1'b0; do_push = 1'b0; do_app = 1'b0;
    pop = 1'b0; victim = 1'b0;
    tgt = '0; rm_f = hit_idx;
    st = ST_OK; wb = 1'b0; rd = 1'b0; wf = '0; wp = '0; lst = 1'b1;
    higher = '0;
    for (int i = 0; i < POOL_FRAMES; i++) fcmd[i] = '0;

    case (state_q)
      S_IDLE: if (s_tvalid) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_SEND;
        if (op_q == OP_FLUSH_ALL) begin
          for (int i = 0; i < POOL_FRAMES; i++)
            if (fa_vec[i]) begin
              fcmd[i].dirty_we  = 1'b1;
              fcmd[i].dirty_val = 1'b0;
            end
          k_d = '0;
          n_d = '0;
          if (fa_vec != '0) state_d = S_SCAN;
        end else if (op_q == OP_NEW && hit_any) begin
          st = ST_INVALID;
        end else if (op_q > OP_FLUSH_ALL || (op_q != OP_NEW && neg_q)) begin
          st = ST_INVALID;
        end else if (op_q == OP_NEW || (op_q == OP_FETCH && !hit_any)) begin
          // Frame allocation: free stack first, then the LRU victim.
          if (free_cnt_q != '0) begin
            tgt = fs_val[0];
            pop = 1'b1;
            do_load = 1'b1;
          end else if (lru_cnt_q != '0) begin
            tgt = lr_val[0];
            rm_f = lr_val[0];
            victim = 1'b1;
            do_rm = 1'b1;
            do_load = 1'b1;
            if (fv[lr_val[0]] && fd[lr_val[0]]) begin
              wb = 1'b1;
              wf = ff[lr_val[0]];
              wp = fp[lr_val[0]];
            end
          end else begin
            st = ST_NO_FRAME;
          end
          if (do_load) begin
            rd = 1'b1;
            fcmd[tgt].load = 1'b1;
          end
        end else begin
          tgt = hit_idx;
          case (op_q)
            OP_FETCH: begin
              fcmd[tgt].pin_inc = 1'b1;
              do_rm = 1'b1;
            end
            OP_UNPIN: begin
              if (!hit_any) begin
                st = ST_NOT_RES; tgt = '0;
              end else if (fpin[tgt] == '0) begin
                st = ST_NOT_PINNED;
              end else begin
                fcmd[tgt].pin_dec   = 1'b1;
                fcmd[tgt].dirty_we  = 1'b1;
                fcmd[tgt].dirty_val = md_q;
                if (fpin[tgt] == PinW'(1)) do_app = 1'b1;
              end
            end
            OP_FLUSH: begin
              if (!hit_any) begin
                st = ST_NOT_RES; tgt = '0;
              end else begin
                fcmd[tgt].dirty_we  = 1'b1;
                fcmd[tgt].dirty_val = 1'b0;
                wb = 1'b1; wf = fid_q; wp = pno_q;
              end
            end
            default: begin
              if (!hit_any) begin
                tgt = '0;
              end else if (fpin[tgt] != '0) begin
                st = ST_PINNED;
              end else begin
                do_rm = 1'b1;
                fcmd[tgt].kill = 1'b1;
                do_push = 1'b1;
                wb = 1'b1; wf = fid_q; wp = pno_q;
              end
            end
          endcase
        end
        ov_d = 1'b1;
        ol_d = 1'b1;
        od_d = {rd, wp, wf, wb, FrameOutW'(tgt), st};
        if (state_d == S_SCAN) ov_d = 1'b0;
      end
      S_SCAN: begin
        if (out_free) begin
          if (fa_vec[k_q]) begin
            higher = (fa_vec >> k_q) >> 1;
            lst = (higher == '0) || (n_q == RW'(MaxResults - 1));
            ov_d = 1'b1;
            ol_d = lst;
            od_d = {1'b0, fp[k_q], fid_q, 1'b1, FrameOutW'(k_q), 3'(ST_OK)};
            n_d = n_q + RW'(1);
            if (lst) state_d = S_SEND;
          end
          k_d = k_q + FW'(1);
        end
      end
      S_SEND: if (ov_q && m_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    // Free stack update: a push moves every occupied slot one place down, a pop moves all slots one place up.
    fs_load = hit_idx;
    for (int i = 0; i < POOL_FRAMES; i++) begin
      fs_cmd[i].take_next = pop;
      fs_cmd[i].take_prev = do_push && CW'(i) <= free_cnt_q;
      fs_cmd[i].load      = do_push && i == 0;
    end
    if (pop) free_cnt_d = free_cnt_q - CW'(1);
    if (do_push && free_cnt_q < CW'(POOL_FRAMES)) free_cnt_d = free_cnt_q + CW'(1);

    // LRU list update: the removed entry drops out, later slots close the gap, and an append loads at the tail.
    lr_load = hit_idx;
    for (int i = 0; i < POOL_FRAMES; i++) begin
      if (i == 0) lr_seen[i] = lr_val[i] == rm_f && lru_cnt_q != '0;
      else lr_seen[i] = lr_seen[i-1] || (lr_val[i] == rm_f && CW'(i) < lru_cnt_q);
      lr_cmd[i].take_next = do_rm && lr_seen[i];
      lr_cmd[i].take_prev = 1'b0;
      lr_cmd[i].load      = do_app && CW'(i) == lru_cnt_q;
    end
    if (do_rm && lr_seen[POOL_FRAMES-1]) lru_cnt_d = lru_cnt_q - CW'(1);
    if (do_app && lru_cnt_q < CW'(POOL_FRAMES)) lru_cnt_d = lru_cnt_q + CW'(1);
    if (victim) load_page = key_page;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ov_q       <= 1'b0;
      free_cnt_q <= CW'(POOL_FRAMES);
      lru_cnt_q  <= '0;
      k_q        <= '0;
      n_q        <= '0;
    end else begin
      state_q    <= state_d;
      ov_q       <= ov_d;
      free_cnt_q <= free_cnt_d;
      lru_cnt_q  <= lru_cnt_d;
      k_q        <= k_d;
      n_q        <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ol_q <= ol_d;
    od_q <= od_d;
  end

  assign m_tvalid = ov_q;
  assign m_tdata  = {7'd0, od_q};
  assign m_tlast  = ol_q;

  // The free and LRU counts together never exceed the pool size.
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_cnt_q + lru_cnt_q) <= CW'(POOL_FRAMES))
    else $error("free and LRU counts exceed pool size");

  // No result may be pending while a new request is taken.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready |-> !m_tvalid)
    else $error("result pending in idle");

  // A result word issued before the scan leaves must not be the last.
  a_scan_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && m_tvalid) |-> !m_tlast)
    else $error("last word while scan continues");

endmodule
